// ===== design/bsm_pkg.sv =====
// Shared types for the Booth signed multiplier: controller states and control bundles.
package bsm_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } bsm_state_t;

    typedef struct packed {
        logic load;     // take a new operand pair
        logic step;     // run one Booth round
        logic capture;  // move the finished product into the output register
    } bsm_cmd_t;

    typedef struct packed {
        logic last_round;
    } bsm_status_t;

endpackage

// ===== design/bsm_ctrl.sv =====
// Controller for the Booth signed multiplier: sequencing and output handshake.
module bsm_ctrl
    import bsm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  bsm_status_t status,
    output bsm_cmd_t    cmd
);

    bsm_state_t state_reg;
    bsm_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        slot_free      = !out_valid_reg || out_ready;
        in_ready       = 1'b0;
        cmd            = '0;
        state_next     = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
                if (status.last_round)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hold the product until the output register frees up.
                if (slot_free)
                begin
                    in_ready    = 1'b1;
                    cmd.capture = 1'b1;
                    state_next  = in_valid ? ST_RUN : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        cmd.load = in_valid && in_ready;

        if (cmd.capture)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== design/bsm_datapath.sv =====
// Datapath for the Booth signed multiplier: accumulator, shifted multiplier, round counter.
module bsm_datapath
    import bsm_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  bsm_cmd_t               cmd,
    input  logic [WIDTH-1:0]       multiplicand,
    input  logic [WIDTH-1:0]       multiplier,
    output logic [2*WIDTH-1:0]     product,
    output bsm_status_t            status
);

    localparam int CNT_W = $clog2(WIDTH);

    logic [WIDTH:0]     mcand_reg;
    logic [WIDTH:0]     acc_reg;
    logic [WIDTH-1:0]   mult_reg;
    logic               prior_reg;
    logic [CNT_W-1:0]   round_reg;
    logic [2*WIDTH-1:0] product_reg;
    logic [WIDTH:0]     sum;

    always_comb
    begin
        priority if (mult_reg[0] && !prior_reg)
        begin
            sum = acc_reg - mcand_reg;
        end
        else if (!mult_reg[0] && prior_reg)
        begin
            sum = acc_reg + mcand_reg;
        end
        else
        begin
            sum = acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_reg <= '0;
        end
        else if (cmd.load)
        begin
            round_reg <= '0;
        end
        else if (cmd.step)
        begin
            round_reg <= round_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        // Capture reads the finished registers before a same-cycle load overwrites them.
        if (cmd.capture)
        begin
            product_reg <= {acc_reg[WIDTH-1:0], mult_reg};
        end
        if (cmd.load)
        begin
            mcand_reg <= {multiplicand[WIDTH-1], multiplicand};
            acc_reg   <= '0;
            mult_reg  <= multiplier;
            prior_reg <= 1'b0;
        end
        else if (cmd.step)
        begin
            // Arithmetic right shift through accumulator, multiplier and prior bit.
            prior_reg <= mult_reg[0];
            mult_reg  <= {sum[0], mult_reg[WIDTH-1:1]};
            acc_reg   <= {sum[WIDTH], sum[WIDTH:1]};
        end
    end

    assign status.last_round = (round_reg == CNT_W'(WIDTH - 1));
    assign product           = product_reg;

endmodule

// ===== design/booth_signed_multiplier_unit.sv =====
// Top level of the radix-2 Booth signed multiplier with stream ports.
// Sequence: load the accepted input word, run the WIDTH add-and-shift rounds of
// the single shared adder, then, once the output register is free, move the product
// there and raise m_tvalid. No new word is taken while rounds run; the next word
// loads in the same cycle the previous product moves to the output register.
// Reset: rst_n asynchronous, active low; clears controller state and m_tvalid.
module booth_signed_multiplier_unit
    import bsm_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // fields from bit 0: multiplicand (WIDTH), multiplier (WIDTH), zero pad to bytes
    input  logic [((2*WIDTH+7)/8)*8-1:0]       s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // fields from bit 0: product (2*WIDTH), zero pad to bytes
    output logic [((2*WIDTH+7)/8)*8-1:0]       m_tdata
);

    localparam int DATA_W = ((2*WIDTH+7)/8)*8;

    bsm_cmd_t           cmd;
    bsm_status_t        status;
    logic [2*WIDTH-1:0] product;

    // Sequence the rounds and own the output valid flag.
    bsm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // Hold operands, run the Booth rounds, register the product.
    bsm_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .multiplicand (s_tdata[WIDTH-1:0]),
        .multiplier   (s_tdata[2*WIDTH-1:WIDTH]),
        .product      (product),
        .status       (status)
    );

    // Pad the product with zeros up to whole bytes.
    assign m_tdata = DATA_W'(product);

endmodule

// ===== design/bsm_checker.sv =====
// Port-level checker for the Booth signed multiplier, bound to the top level.
module bsm_checker #(
    parameter int WIDTH = 8
)
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [((2*WIDTH+7)/8)*8-1:0] s_tdata,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [((2*WIDTH+7)/8)*8-1:0] m_tdata
);

    // A stalled output word holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    // Only one word in flight: an accept closes the input side next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a word is in progress");

    // A new result follows a running round, never an idle input side.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready, 2))
        else $error("result appeared without a completed computation");

    // Reset leaves no result pending.
    assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("output valid set out of reset");

    // A waiting input word holds its value until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> $stable(s_tdata))
        else $error("input word changed while waiting");

endmodule

bind booth_signed_multiplier_unit bsm_checker #(
    .WIDTH (WIDTH)
) u_bsm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
